[hdl/joystick_cursor_conditioner_defines.svh]
// assertion macros for the joystick cursor conditioner
// no dependencies; expects clk and arst_n in the scope that uses them
`ifndef JOYSTICK_CURSOR_CONDITIONER_DEFINES_SVH
`define JOYSTICK_CURSOR_CONDITIONER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JCC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jcc: same-cycle check failed");
// next-cycle implication
`define JCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jcc: next-cycle check failed");
`else
`define JCC_ASSERT_IMPL(lbl, ante, cons)
`define JCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/jcc_pkg.sv]
// shared types and constants of the joystick cursor conditioner
// no dependencies
package jcc_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;

	localparam int ADC_W        = 12;
	localparam int ADC_TOP      = 4095;
	localparam int REL_DEAD     = 200;
	localparam int REL_DIV      = 200;
	localparam int REL_STEP_MAX = 3;
	localparam int BTN_STEP     = 4;
	localparam int ABS_DEAD     = 260;
	localparam int SMOOTH_OLD   = 7;
	localparam int SMOOTH_SHIFT = 3;
	localparam int MIN_SPAN     = 64;

	localparam int COL_W  = 9;
	localparam int ROW_W  = 8;
	localparam int SZ_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int BTN_W  = SZ_W + 2;
	localparam int SM_W   = ADC_W + SMOOTH_SHIFT;
	localparam int QUO_W  = SZ_W;
	localparam int NUM_W  = ADC_W + SZ_W + 1;
	localparam int CNT_W  = $clog2(QUO_W);
	localparam int STEP_W = 2;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;

	typedef struct packed {
		logic [ADC_W-1:0] raw_x;
		logic [ADC_W-1:0] raw_y;
		logic             left_pressed;
		logic             right_pressed;
	} sample_t;

	typedef struct packed {
		logic [COL_W-1:0] pos_x;
		logic [ROW_W-1:0] pos_y;
	} cursor_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ABS_MODE  = 4'd0,
		REG_CENTER_X  = 4'd1,
		REG_CENTER_Y  = 4'd2,
		REG_CAL_X_MIN = 4'd3,
		REG_CAL_X_MAX = 4'd4,
		REG_CAL_Y_MIN = 4'd5,
		REG_CAL_Y_MAX = 4'd6,
		REG_INVERT    = 4'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_REL,
		ST_OUT
	} state_t;

endpackage

[hdl/jcc_divider.sv]
// restoring divider, one quotient bit per cycle, shared by both axes
// depends on jcc_pkg
module jcc_divider import jcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [ADC_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [NUM_W-1:0] trial;
	logic             fits;

	assign trial = NUM_W'(den) << cnt_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q && fits) begin
			rem_q        <= rem_q - trial;
			quo_q[cnt_q] <= 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/joystick_cursor_conditioner.sv]
// top level of the joystick cursor conditioner: config registers, sequencer, datapath
// depends on jcc_pkg, jcc_divider and joystick_cursor_conditioner_defines.svh
//
// usage
// - sample channel (sample_valid/sample_ready/sample): one word per joystick sample,
//   two 12-bit axis readings and two button levels
// - cursor channel (cursor_valid/cursor_ready/cursor): one word per sample with the
//   cursor column and row after that sample
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes, always
//   ready; write only while no sample is in flight
// - absolute mode: each axis runs prep, multiply, the shared restoring divider and
//   finish, and the two axes take turns on that one divider
// - relative mode: the sequencer runs the relative move and then the output state
// - sample_ready is high only while the sequencer is idle
// - the cursor word sits in an output register; the next sample is taken while
//   it waits, and the sequencer holds in its last state only when a new result
//   is ready and the old word is still not taken
// - reset: registers go to their defaults, smoothing to mid scale, cursor to
//   mid screen, no cursor word pending
module joystick_cursor_conditioner import jcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  cursor_valid,
	input  logic                  cursor_ready,
	output cursor_t               cursor,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "joystick_cursor_conditioner_defines.svh"

	localparam logic [SZ_W-1:0] X_M1 = SZ_W'(SCREEN_WIDTH - 1);
	localparam logic [SZ_W-1:0] Y_M1 = SZ_W'(SCREEN_HEIGHT - 1);

	// configuration registers
	logic             abs_mode_q;
	logic [ADC_W-1:0] ctr_x_q, ctr_y_q;
	logic [ADC_W-1:0] cal_x_min_q, cal_x_max_q, cal_y_min_q, cal_y_max_q;
	logic [1:0]       invert_q;

	// item state
	logic [ADC_W-1:0] smooth_x_q, smooth_y_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	sample_t          samp_q;

	// sequencer and per-axis working registers
	state_t           state_q, state_d;
	logic             on_y_q;
	logic [ADC_W-1:0] off_q;
	logic [ADC_W-1:0] span_q;
	logic             dead_q;
	logic             inv_q;

	logic             out_valid_q;
	cursor_t          out_q;

	logic             accept;
	logic             div_start;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;
	logic             out_load;

	assign cfg_ready = 1'b1;
	assign accept    = sample_valid && sample_ready;

	// ---------------- configuration writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_mode_q  <= 1'b0;
			ctr_x_q     <= ADC_W'(2047);
			ctr_y_q     <= ADC_W'(2047);
			cal_x_min_q <= '0;
			cal_x_max_q <= ADC_W'(ADC_TOP);
			cal_y_min_q <= '0;
			cal_y_max_q <= ADC_W'(ADC_TOP);
			invert_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ABS_MODE:  abs_mode_q  <= cfg_data[0];
				REG_CENTER_X:  ctr_x_q     <= cfg_data[ADC_W-1:0];
				REG_CENTER_Y:  ctr_y_q     <= cfg_data[ADC_W-1:0];
				REG_CAL_X_MIN: cal_x_min_q <= cfg_data[ADC_W-1:0];
				REG_CAL_X_MAX: cal_x_max_q <= cfg_data[ADC_W-1:0];
				REG_CAL_Y_MIN: cal_y_min_q <= cfg_data[ADC_W-1:0];
				REG_CAL_Y_MAX: cal_y_max_q <= cfg_data[ADC_W-1:0];
				REG_INVERT:    invert_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// ---------------- smoothing: (7*old + raw) >> 3 ----------------
	logic [SM_W-1:0] sm_sum_x, sm_sum_y;

	assign sm_sum_x = SM_W'(smooth_x_q) * SM_W'(SMOOTH_OLD) + SM_W'(sample.raw_x);
	assign sm_sum_y = SM_W'(smooth_y_q) * SM_W'(SMOOTH_OLD) + SM_W'(sample.raw_y);

	// ---------------- axis select ----------------
	logic [ADC_W-1:0] rd_raw, rd_ctr, rd_a, rd_b;
	logic [SZ_W-1:0]  rd_m1;
	logic             rd_inv;

	always_comb begin
		if (on_y_q) begin
			rd_raw = smooth_y_q;
			rd_ctr = ctr_y_q;
			rd_a   = cal_y_min_q;
			rd_b   = cal_y_max_q;
			rd_m1  = Y_M1;
			rd_inv = invert_q[1];
		end else begin
			rd_raw = smooth_x_q;
			rd_ctr = ctr_x_q;
			rd_a   = cal_x_min_q;
			rd_b   = cal_x_max_q;
			rd_m1  = X_M1;
			rd_inv = invert_q[0];
		end
	end

	// ---------------- prep: order bounds, narrow span fallback, clamp, dead zone ----------------
	logic [ADC_W-1:0] lo_sw, hi_sw, span_sw, lo_c, hi_c, rc, ctr_gap;
	logic             narrow;

	always_comb begin
		lo_sw   = (rd_a > rd_b) ? rd_b : rd_a;
		hi_sw   = (rd_a > rd_b) ? rd_a : rd_b;
		span_sw = hi_sw - lo_sw;
		narrow  = span_sw < ADC_W'(MIN_SPAN);
		lo_c    = narrow ? '0 : lo_sw;
		hi_c    = narrow ? ADC_W'(ADC_TOP) : hi_sw;
		if (rd_raw < lo_c) begin
			rc = lo_c;
		end else if (rd_raw > hi_c) begin
			rc = hi_c;
		end else begin
			rc = rd_raw;
		end
		ctr_gap = (rc >= rd_ctr) ? (rc - rd_ctr) : (rd_ctr - rc);
	end

	// ---------------- multiply: numerator with half-span rounding ----------------
	logic [NUM_W-1:0] num_c;

	assign num_c = NUM_W'(off_q) * NUM_W'(rd_m1) + NUM_W'(span_q >> 1);

	jcc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_c),
		.den    (span_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ---------------- finish: dead zone snap, inversion, clamp ----------------
	logic [SZ_W-1:0] mapped;

	always_comb begin
		if (dead_q) begin
			mapped = rd_m1 >> 1;
		end else if (inv_q) begin
			mapped = (div_quo > rd_m1) ? '0 : (rd_m1 - div_quo);
		end else begin
			mapped = (div_quo > rd_m1) ? rd_m1 : div_quo;
		end
	end

	// ---------------- relative move ----------------
	function automatic logic [SZ_W-1:0] rel_next(
		input logic [SZ_W-1:0]  pos,
		input logic [ADC_W-1:0] raw,
		input logic [ADC_W-1:0] ctr,
		input logic [SZ_W-1:0]  m1
	);
		logic signed [ADC_W:0]  diff;
		logic                   neg;
		logic [ADC_W-1:0]       mag;
		logic [STEP_W-1:0]      step;
		logic [BTN_W-1:0]       p;
		logic [SZ_W-1:0]        res;
		diff = $signed({1'b0, raw}) - $signed({1'b0, ctr});
		neg  = diff[ADC_W];
		mag  = neg ? ADC_W'(-diff) : ADC_W'(diff);
		if (mag < ADC_W'(REL_DEAD)) begin
			step = '0;
		end else if (mag >= ADC_W'(REL_STEP_MAX * REL_DIV)) begin
			step = STEP_W'(REL_STEP_MAX);
		end else if (mag >= ADC_W'(2 * REL_DIV)) begin
			step = STEP_W'(2);
		end else if (mag >= ADC_W'(REL_DIV)) begin
			step = STEP_W'(1);
		end else begin
			step = '0;
		end
		p = neg ? (BTN_W'(pos) - BTN_W'(step)) : (BTN_W'(pos) + BTN_W'(step));
		if ($signed(p) < 0) begin
			res = '0;
		end else if ($signed(p) > $signed(BTN_W'(m1))) begin
			res = m1;
		end else begin
			res = p[SZ_W-1:0];
		end
		return res;
	endfunction

	logic [SZ_W-1:0] rel_col, rel_row;

	assign rel_col = rel_next(SZ_W'(col_q), samp_q.raw_x, ctr_x_q, X_M1);
	assign rel_row = rel_next(SZ_W'(row_q), samp_q.raw_y, ctr_y_q, Y_M1);

	// ---------------- buttons: -4 / +4 on the column, then clamp ----------------
	logic [BTN_W-1:0] btn_sum;
	logic [COL_W-1:0] btn_col;

	always_comb begin
		btn_sum = BTN_W'(col_q)
			+ (samp_q.right_pressed ? BTN_W'(BTN_STEP) : '0)
			- (samp_q.left_pressed ? BTN_W'(BTN_STEP) : '0);
		if ($signed(btn_sum) < 0) begin
			btn_col = '0;
		end else if ($signed(btn_sum) > $signed(BTN_W'(SCREEN_WIDTH - 1))) begin
			btn_col = COL_W'(SCREEN_WIDTH - 1);
		end else begin
			btn_col = btn_sum[COL_W-1:0];
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = abs_mode_q ? ST_PREP : ST_REL;
				end
			end
			ST_PREP: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = on_y_q ? ST_OUT : ST_PREP;
			ST_REL:  state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || cursor_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = (state_q == ST_IDLE);
		div_start    = (state_q == ST_MUL);
		out_load     = (state_q == ST_OUT) && (!out_valid_q || cursor_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			on_y_q      <= 1'b0;
			smooth_x_q  <= ADC_W'(2047);
			smooth_y_q  <= ADC_W'(2047);
			col_q       <= COL_W'(SCREEN_WIDTH / 2);
			row_q       <= ROW_W'(SCREEN_HEIGHT / 2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				on_y_q <= 1'b0;
				if (abs_mode_q) begin
					smooth_x_q <= sm_sum_x[SM_W-1:SMOOTH_SHIFT];
					smooth_y_q <= sm_sum_y[SM_W-1:SMOOTH_SHIFT];
				end
			end
			if (state_q == ST_FIN) begin
				on_y_q <= 1'b1;
				if (on_y_q) begin
					row_q <= mapped[ROW_W-1:0];
				end else begin
					col_q <= mapped[COL_W-1:0];
				end
			end
			if (state_q == ST_REL) begin
				col_q <= rel_col[COL_W-1:0];
				row_q <= rel_row[ROW_W-1:0];
			end
			if (out_load) begin
				col_q       <= btn_col;
				out_valid_q <= 1'b1;
			end else if (cursor_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= sample;
		end
		if (state_q == ST_PREP) begin
			off_q  <= rc - lo_c;
			span_q <= hi_c - lo_c;
			dead_q <= ctr_gap <= ADC_W'(ABS_DEAD);
			inv_q  <= rd_inv;
		end
		if (out_load) begin
			out_q.pos_x <= btn_col;
			out_q.pos_y <= row_q;
		end
	end

	assign cursor_valid = out_valid_q;
	assign cursor       = out_q;

	// ---------------- checks ----------------
	`JCC_ASSERT_IMPL(a_done_in_div, div_done, state_q == ST_DIV)
	`JCC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
	`JCC_ASSERT_IMPL(a_col_range, 1'b1, col_q <= COL_W'(SCREEN_WIDTH - 1))
	`JCC_ASSERT_IMPL(a_row_range, 1'b1, row_q <= ROW_W'(SCREEN_HEIGHT - 1))

endmodule

[tb/joystick_cursor_conditioner_test.sv]
// self-checking bench for the joystick cursor conditioner, bursty sender and stalling receiver
// depends on jcc_pkg and the joystick_cursor_conditioner rtl
module joystick_cursor_conditioner_test;
	import jcc_pkg::*;

	// first index past the register file, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE_BASE = 4'd8;
	// cycles to let pass before touching registers, covers the absolute-mode latency
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES = 12;
	localparam int PHASE_WORDS = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic sample_valid = 1'b0;
	logic sample_ready;
	sample_t sample = '0;
	logic cursor_valid;
	logic cursor_ready = 1'b0;
	cursor_t cursor;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	joystick_cursor_conditioner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.cursor_valid (cursor_valid),
		.cursor_ready (cursor_ready),
		.cursor       (cursor),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// samples waiting for the driver, and cursor words the block still owes us
	sample_t sample_pending_q[$];
	cursor_t cursor_due_q[$];
	int queued_count = 0;
	int accepted_count = 0;
	int fault_count = 0;

	// handshake flags seen at the rising edge, consumed at the falling edge
	logic sample_fired = 1'b0;
	logic cfg_fired = 1'b0;

	// shadow of the register file, reset values
	bit mode_abs = 1'b0;
	int ctr_x = 2047;
	int ctr_y = 2047;
	int xmin = 0;
	int xmax = ADC_TOP;
	int ymin = 0;
	int ymax = ADC_TOP;
	bit [1:0] flip = 2'b00;

	// shadow of the block state: smoothing filters and the cursor itself
	int filt_x = 2047;
	int filt_y = 2047;
	int col = SCREEN_WIDTH / 2;
	int row = SCREEN_HEIGHT / 2;

	function automatic int clip(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// absolute mapping of one smoothed axis onto 0..size-1
	function automatic int abs_axis(int rd, int ctr, int lo, int hi, int size, bit inv);
		int t;
		int span;
		int coord;
		int gap;
		// swapped bounds get exchanged
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		// too narrow a span falls back to the whole converter range
		if (hi - lo < MIN_SPAN) begin
			lo = 0;
			hi = ADC_TOP;
		end
		// reading clipped into the span before mapping and dead-zone test
		rd = clip(rd, lo, hi);
		span = hi - lo;
		coord = ((rd - lo) * (size - 1) + span / 2) / span;
		gap = rd - ctr;
		if (gap < 0) gap = -gap;
		if (gap <= ABS_DEAD) return (size - 1) / 2;
		if (inv) coord = (size - 1) - coord;
		return clip(coord, 0, size - 1);
	endfunction

	// relative step of one axis, dead zone then truncating divide
	function automatic int rel_axis(int pos, int rd, int ctr, int size);
		int diff;
		int step;
		diff = rd - ctr;
		if (diff > -REL_DEAD && diff < REL_DEAD) diff = 0;
		step = clip(diff / REL_DIV, -REL_STEP_MAX, REL_STEP_MAX);
		return clip(pos + step, 0, size - 1);
	endfunction

	// advances the shadow state by one sample and returns the cursor word it implies
	function automatic cursor_t advance_cursor(sample_t s);
		cursor_t r;
		if (mode_abs) begin
			filt_x = (SMOOTH_OLD * filt_x + int'(s.raw_x)) / (1 << SMOOTH_SHIFT);
			filt_y = (SMOOTH_OLD * filt_y + int'(s.raw_y)) / (1 << SMOOTH_SHIFT);
			col = abs_axis(filt_x, ctr_x, xmin, xmax, SCREEN_WIDTH, flip[0]);
			row = abs_axis(filt_y, ctr_y, ymin, ymax, SCREEN_HEIGHT, flip[1]);
		end else begin
			// filters stay frozen in relative mode
			col = rel_axis(col, int'(s.raw_x), ctr_x, SCREEN_WIDTH);
			row = rel_axis(row, int'(s.raw_y), ctr_y, SCREEN_HEIGHT);
		end
		if (s.left_pressed) col -= BTN_STEP;
		if (s.right_pressed) col += BTN_STEP;
		col = clip(col, 0, SCREEN_WIDTH - 1);
		r.pos_x = COL_W'(col);
		r.pos_y = ROW_W'(row);
		return r;
	endfunction

	// monitor: everything is sampled at the rising edge
	always @(posedge clk) begin : watch
		cursor_t want;
		sample_fired <= sample_valid && sample_ready;
		cfg_fired <= cfg_valid && cfg_ready;

		// result side first, a word can never belong to a sample taken at this same edge
		if (cursor_valid && cursor_ready) begin
			if (cursor_due_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected cursor word x=%0d y=%0d", cursor.pos_x, cursor.pos_y);
			end else begin
				want = cursor_due_q.pop_front();
				if (cursor.pos_x !== want.pos_x || cursor.pos_y !== want.pos_y) begin
					fault_count++;
					if (fault_count <= 10)
						$display("cursor mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							want.pos_x, want.pos_y, cursor.pos_x, cursor.pos_y);
				end
			end
		end

		// register writes land in the shadow with the block's masking
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ABS_MODE:  mode_abs = cfg_data[0];
				REG_CENTER_X:  ctr_x = int'(cfg_data);
				REG_CENTER_Y:  ctr_y = int'(cfg_data);
				REG_CAL_X_MIN: xmin = int'(cfg_data);
				REG_CAL_X_MAX: xmax = int'(cfg_data);
				REG_CAL_Y_MIN: ymin = int'(cfg_data);
				REG_CAL_Y_MAX: ymax = int'(cfg_data);
				REG_INVERT:    flip = cfg_data[1:0];
				default: ;
			endcase
		end

		if (sample_valid && sample_ready) begin
			cursor_due_q.push_back(advance_cursor(sample));
			accepted_count++;
		end
	end

	// driver: bursts of words separated by random gaps, changes at the falling edge
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin : drive
		logic hold;
		hold = sample_valid && !sample_fired;
		if (!hold) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (sample_pending_q.size() != 0) begin
				sample <= sample_pending_q.pop_front();
				hold = 1'b1;
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					// a quarter of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		sample_valid <= hold;
	end

	// receiver: rotating ready pattern, swapped out every so often
	logic [15:0] ready_pattern = '1;
	int pattern_left = 0;

	always @(negedge clk) begin : stall
		if (pattern_left == 0) begin
			pattern_left = $urandom_range(16, 256);
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = 16'($urandom) & 16'($urandom);
				default: ready_pattern = 16'($urandom);
			endcase
			// at least one ready per rotation keeps the longest stall bounded
			ready_pattern[0] = 1'b1;
		end else begin
			pattern_left--;
		end
		ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
		cursor_ready <= ready_pattern[0];
	end

	task automatic queue_sample(input int rx, input int ry, input bit l, input bit r);
		sample_t s;
		s.raw_x = ADC_W'(rx);
		s.raw_y = ADC_W'(ry);
		s.left_pressed = l;
		s.right_pressed = r;
		sample_pending_q.push_back(s);
		queued_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_fired);
		cfg_valid <= 1'b0;
	endtask

	// block is idle once every queued sample went in and every cursor word came back
	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_count != queued_count || cursor_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// a reading biased toward the rails and the dead-zone edges around ctr
	function automatic int pick_reading(int ctr);
		int near_pts [11] = '{199, 200, 201, 259, 260, 261, 399, 400, 599, 600, 800};
		int v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 1) ? ADC_TOP : 0;
			1: v = $urandom_range(0, 1) ? ctr + near_pts[$urandom_range(0, 10)]
				: ctr - near_pts[$urandom_range(0, 10)];
			2: v = ctr + $urandom_range(0, 600) - 300;
			default: v = $urandom_range(0, ADC_TOP);
		endcase
		return clip(v, 0, ADC_TOP);
	endfunction

	function automatic int pick_centre();
		case ($urandom_range(0, 3))
			0: return 2047;
			1: return $urandom_range(0, 1) ? ADC_TOP : 0;
			default: return $urandom_range(0, ADC_TOP);
		endcase
	endfunction

	// calibration pairs: full, swapped, around the narrow-span edge, random
	task automatic pick_span(output int lo, output int hi);
		case ($urandom_range(0, 4))
			0: begin
				lo = 0;
				hi = ADC_TOP;
			end
			1: begin
				hi = $urandom_range(0, ADC_TOP / 2);
				lo = $urandom_range(ADC_TOP / 2, ADC_TOP);
			end
			2: begin
				lo = $urandom_range(0, ADC_TOP);
				hi = clip(lo + $urandom_range(58, 70), 0, ADC_TOP);
				if ($urandom_range(0, 1)) begin
					int t;
					t = lo;
					lo = hi;
					hi = t;
				end
			end
			3: begin
				lo = ADC_TOP;
				hi = 0;
			end
			default: begin
				lo = $urandom_range(0, ADC_TOP);
				hi = $urandom_range(0, ADC_TOP);
			end
		endcase
	endtask

	// one full register setup, junk in the unused data bits of the narrow registers
	task automatic setup_phase(output int cx, output int cy);
		logic [CFG_DATA_W-1:0] noise;
		int lo;
		int hi;
		noise = CFG_DATA_W'($urandom);
		write_reg(REG_ABS_MODE, {noise[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
		cx = pick_centre();
		cy = pick_centre();
		write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
		write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
		pick_span(lo, hi);
		write_reg(REG_CAL_X_MIN, CFG_DATA_W'(lo));
		write_reg(REG_CAL_X_MAX, CFG_DATA_W'(hi));
		pick_span(lo, hi);
		write_reg(REG_CAL_Y_MIN, CFG_DATA_W'(lo));
		write_reg(REG_CAL_Y_MAX, CFG_DATA_W'(hi));
		noise = CFG_DATA_W'($urandom);
		write_reg(REG_INVERT, {noise[CFG_DATA_W-1:2], 2'($urandom_range(0, 3))});
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_NONE_BASE | CFG_IDX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom));
	endtask

	initial begin : stimulus
		int cx;
		int cy;
		int n;
		int run;
		int rx;
		int ry;
		bit l;
		bit r;
		bit hold_btn;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// relative mode with reset registers: rest, rails, dead-zone edges, buttons
		queue_sample(2047, 2047, 0, 0);
		queue_sample(ADC_TOP, 0, 0, 0);
		queue_sample(0, ADC_TOP, 0, 0);
		queue_sample(2047 + 199, 2047 - 199, 0, 0);
		queue_sample(2047 + 200, 2047 - 200, 1, 0);
		queue_sample(2047 + 599, 2047 - 600, 0, 1);
		queue_sample(0, 0, 1, 1);
		queue_sample(ADC_TOP, ADC_TOP, 1, 1);
		wait_drained();

		// absolute mode, both axes inverted, set through writes with junk upper bits
		write_reg(REG_ABS_MODE, 12'hABD);
		write_reg(REG_INVERT, 12'hFFF);
		write_reg(REG_NONE_BASE, 12'hFFF);
		write_reg(REG_NONE_BASE | CFG_IDX_W'(7), 12'h000);
		repeat (3) queue_sample(ADC_TOP, ADC_TOP, 0, 0);
		repeat (3) queue_sample(0, 0, 0, 0);
		queue_sample(2047, 2047, 1, 1);
		wait_drained();

		// swapped x bounds, narrow y span, centres at the rails, reading outside span
		write_reg(REG_CAL_X_MIN, 12'd3000);
		write_reg(REG_CAL_X_MAX, 12'd1000);
		write_reg(REG_CAL_Y_MIN, 12'd2000);
		write_reg(REG_CAL_Y_MAX, 12'd2063);
		write_reg(REG_CENTER_X, 12'd0);
		write_reg(REG_CENTER_Y, 12'd4095);
		write_reg(REG_INVERT, 12'h000);
		queue_sample(ADC_TOP, 0, 1, 0);
		queue_sample(0, ADC_TOP, 0, 1);
		queue_sample(2000, 2000, 0, 0);
		wait_drained();

		// relative detour must leave the filters where they were
		write_reg(REG_ABS_MODE, 12'h000);
		queue_sample(2047, 2047, 0, 0);
		queue_sample(ADC_TOP, 0, 0, 0);
		wait_drained();
		write_reg(REG_ABS_MODE, 12'h001);
		queue_sample(1500, 2500, 0, 0);
		wait_drained();

		// random phases, each with its own register setup
		for (int p = 0; p < PHASES; p++) begin
			setup_phase(cx, cy);
			n = 0;
			while (n < PHASE_WORDS) begin
				// mostly held readings so the filters settle and the cursor reaches the edges
				run = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
				rx = pick_reading(cx);
				ry = pick_reading(cy);
				hold_btn = $urandom_range(0, 1);
				l = ($urandom_range(0, 3) == 0);
				r = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < run && n < PHASE_WORDS; k++) begin
					if (!hold_btn) begin
						l = $urandom_range(0, 1);
						r = $urandom_range(0, 1);
					end
					queue_sample(rx, ry, l, r);
					n++;
				end
			end
			wait_drained();
		end

		if (fault_count == 0)
			$display("[joystick_cursor_conditioner] OK");
		else
			$display("[joystick_cursor_conditioner] ERROR");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin : watchdog
		#8000000;
		$display("[joystick_cursor_conditioner] ERROR");
		$finish;
	end

endmodule
